// ===== rtl/khi_pkg.sv =====
// Shared constants and record types of the keyframe Hermite interpolator.
package khi_pkg;

  localparam int DEF_MAX_KEYS  = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam int VAL_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL = 2'd2;

  // Time, position and linear flag of one key.
  typedef struct packed {
    logic signed [VAL_W-1:0] tm;
    logic signed [VAL_W-1:0] px;
    logic signed [VAL_W-1:0] py;
    logic signed [VAL_W-1:0] pz;
    logic                    lin;
  } key_a_t;

  // Out and in tangents of one key.
  typedef struct packed {
    logic signed [VAL_W-1:0] ox;
    logic signed [VAL_W-1:0] oy;
    logic signed [VAL_W-1:0] oz;
    logic signed [VAL_W-1:0] ix;
    logic signed [VAL_W-1:0] iy;
    logic signed [VAL_W-1:0] iz;
  } key_b_t;

endpackage

// ===== rtl/keyframe_hermite_interpolator.sv =====
// Keyframe table with binary search and cubic Hermite or linear blending.
//
// Requests arrive on the input channel (in_valid, in_stall). Command 0 writes a
// key's time, position and linear flag, command 1 its tangents; both finish in
// the cycle they are taken and return nothing. Command 2 evaluates the path at
// time_value and returns one result on the output channel (out_valid,
// out_stall). The key count is to be written through cfg_valid/cfg_ready/cfg_data
// only while the block is idle; the block itself does not enforce this. Key data
// live in two memories with registered reads. An evaluate with no keys goes
// straight to the output stage, one at or beyond an end key reads one or both
// end keys first, and one inside a segment takes one memory read per search step,
// then one quotient bit per cycle in the restoring divider (skipped when no
// division is needed), then twelve passes through the single shared multiplier.
// Only one evaluate is in flight; in_stall stays high until its result is
// loaded into the output register. While the receiver stalls, the result is
// held and write requests are still taken until another evaluate is taken.
// Synchronous reset clears the key count and the control state; the memories
// keep whatever they held and a key must be written before it is used.
module keyframe_hermite_interpolator #(
  parameter int MAX_KEYS  = khi_pkg::DEF_MAX_KEYS,
  parameter int FRAC_BITS = khi_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [khi_pkg::CMD_W-1:0]         cmd,
  input  logic [khi_pkg::IDX_W-1:0]         key_index,
  input  logic signed [khi_pkg::VAL_W-1:0]  time_value,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_a_x,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_a_y,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_a_z,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_b_x,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_b_y,
  input  logic signed [khi_pkg::VAL_W-1:0]  vec_b_z,
  input  logic                              linear_flag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [khi_pkg::VAL_W-1:0]  out_x,
  output logic signed [khi_pkg::VAL_W-1:0]  out_y,
  output logic signed [khi_pkg::VAL_W-1:0]  out_z,
  output logic [khi_pkg::IDX_W-1:0]         segment,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [khi_pkg::CNT_W-1:0]         cfg_data
);
  import khi_pkg::*;

  localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int F   = FRAC_BITS;
  localparam int HW  = F + 3;
  localparam int PW  = VAL_W + HW;
  localparam int AW  = PW + 2;
  localparam int DCW = $clog2(F + 1);
  localparam int SW  = 9;

  localparam logic signed [HW-1:0] ONE_H = HW'(1) << F;
  localparam logic [F-1:0]         U_MAX = {F{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDL, S_SRCH, S_F0, S_F1, S_DIV,
    S_SQ, S_CU, S_H, S_MUL, S_FIN, S_DONE
  } state_t;

  state_t state;

  key_a_t mem_a [MAX_KEYS];
  key_b_t mem_b [MAX_KEYS];
  key_a_t a_rd;
  key_b_t b_rd;
  logic [KW-1:0] rd_addr;
  logic          wr_ok;
  logic [KW-1:0] wr_addr;

  logic [CNT_W-1:0] key_count;
  logic [CW-1:0]    n_q;
  logic [KW-1:0]    last, lo, hi, mid;
  logic signed [VAL_W-1:0] t_q, t0;
  logic          lin;
  logic signed [VAL_W-1:0] p0 [3];
  logic signed [VAL_W-1:0] p1 [3];
  logic signed [VAL_W-1:0] tgo [3];
  logic signed [VAL_W-1:0] tgi [3];
  logic [VAL_W-1:0] dur_q, rem;
  logic [DCW-1:0]   dc;
  logic [F-1:0]     u, u2, u3;
  logic signed [HW-1:0] h [4];
  logic [3:0]       mc;
  logic signed [PW-1:0] prod;
  logic [1:0]       ax_q;
  logic             first_q;
  logic signed [AW-1:0] acc [3];
  logic signed [VAL_W-1:0] r_x, r_y, r_z;
  logic [IDX_W-1:0] r_seg;

  // Search and address logic.
  logic             t_ge_mid;
  logic [KW-1:0]    lo_n, hi_n, mid_n, mid0;
  logic             more_n;
  logic [KW:0]      sum_n, sum0;

  // Segment set-up.
  logic signed [VAL_W:0] dur33, num33;
  logic [VAL_W:0]   rem2;
  logic             ge;

  // Multiplier operands.
  logic [1:0]       ax_sel, term;
  logic signed [VAL_W-1:0] op;
  logic signed [HW-1:0]    wt;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign wr_ok   = ({{(SW-IDX_W){1'b0}}, key_index} < SW'(MAX_KEYS));
  assign wr_addr = KW'(key_index);

  always_comb begin
    t_ge_mid = (a_rd.tm <= t_q);
    lo_n     = t_ge_mid ? mid : lo;
    hi_n     = t_ge_mid ? hi : mid;
    sum_n    = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n    = sum_n[KW:1];
    more_n   = ((hi_n - lo_n) > KW'(1));
    sum0     = {1'b0, last};
    mid0     = sum0[KW:1];
    unique case (state)
      S_RD0:   rd_addr = last;
      S_RDL:   rd_addr = (last > KW'(1)) ? mid0 : '0;
      S_SRCH:  rd_addr = more_n ? mid_n : lo_n;
      S_F0:    rd_addr = lo + KW'(1);
      default: rd_addr = '0;
    endcase
  end

  // In S_F1 a_rd holds the end key and t0 the start key's time.
  always_comb begin
    dur33 = {a_rd.tm[VAL_W-1], a_rd.tm} - {t0[VAL_W-1], t0};
    num33 = {t_q[VAL_W-1], t_q} - {t0[VAL_W-1], t0};
    rem2  = {rem, 1'b0};
    ge    = (rem2 >= {1'b0, dur_q});
  end

  always_comb begin
    ax_sel = (mc[3:2] == 2'd3) ? 2'd0 : mc[3:2];
    term   = mc[1:0];
    case (term)
      2'd0:    op = p0[ax_sel];
      2'd1:    op = lin ? '0 : tgo[ax_sel];
      2'd2:    op = p1[ax_sel];
      default: op = lin ? '0 : tgi[ax_sel];
    endcase
    wt = h[term];
  end

  // Round half up, dropping the F fraction bits, then saturate to 32 bits.
  function automatic logic signed [VAL_W-1:0] finish(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] r;
    s = a + (AW'(1) <<< (F - 1));
    r = s >>> F;
    if (r > $signed({{(AW-VAL_W){1'b0}}, {1'b0, {(VAL_W-1){1'b1}}}}))
      finish = {1'b0, {(VAL_W-1){1'b1}}};
    else if (r < $signed({{(AW-VAL_W){1'b1}}, {1'b1, {(VAL_W-1){1'b0}}}}))
      finish = {1'b1, {(VAL_W-1){1'b0}}};
    else
      finish = r[VAL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && wr_ok && cmd == CMD_KEY)
      mem_a[wr_addr] <= '{tm: time_value, px: vec_a_x, py: vec_a_y, pz: vec_a_z,
                          lin: linear_flag};
    if (in_valid && !in_stall && wr_ok && cmd == CMD_TAN)
      mem_b[wr_addr] <= '{ox: vec_a_x, oy: vec_a_y, oz: vec_a_z,
                          ix: vec_b_x, iy: vec_b_y, iz: vec_b_z};
    a_rd <= mem_a[rd_addr];
    b_rd <= mem_b[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        key_count <= cfg_data;
      // S_DONE decides out_valid itself when it loads a new result.
      if (out_valid && !out_stall && state != S_DONE)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && cmd == CMD_EVAL) begin
            t_q <= time_value;
            if ({{(SW-CNT_W){1'b0}}, key_count} > SW'(MAX_KEYS)) begin
              n_q  <= CW'(MAX_KEYS);
              last <= KW'(MAX_KEYS - 1);
            end else begin
              n_q  <= CW'(key_count);
              last <= KW'(key_count - CNT_W'(1));
            end
            if (key_count == '0) begin
              r_x   <= '0;
              r_y   <= '0;
              r_z   <= '0;
              r_seg <= '0;
              state <= S_DONE;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          t0 <= a_rd.tm;
          if (n_q == CW'(1) || t_q <= a_rd.tm) begin
            r_x   <= a_rd.px;
            r_y   <= a_rd.py;
            r_z   <= a_rd.pz;
            r_seg <= '0;
            state <= S_DONE;
          end else begin
            state <= S_RDL;
          end
        end
        S_RDL: begin
          lo <= '0;
          hi <= last;
          if (t_q >= a_rd.tm) begin
            r_x   <= a_rd.px;
            r_y   <= a_rd.py;
            r_z   <= a_rd.pz;
            r_seg <= IDX_W'(last);
            state <= S_DONE;
          end else if (last > KW'(1)) begin
            mid   <= mid0;
            state <= S_SRCH;
          end else begin
            state <= S_F0;
          end
        end
        S_SRCH: begin
          lo  <= lo_n;
          hi  <= hi_n;
          mid <= mid_n;
          if (!more_n)
            state <= S_F0;
        end
        S_F0: begin
          t0     <= a_rd.tm;
          lin    <= a_rd.lin;
          p0[0]  <= a_rd.px;
          p0[1]  <= a_rd.py;
          p0[2]  <= a_rd.pz;
          tgo[0] <= b_rd.ox;
          tgo[1] <= b_rd.oy;
          tgo[2] <= b_rd.oz;
          r_x    <= a_rd.px;
          r_y    <= a_rd.py;
          r_z    <= a_rd.pz;
          r_seg  <= IDX_W'(lo);
          state  <= S_F1;
        end
        S_F1: begin
          p1[0]  <= a_rd.px;
          p1[1]  <= a_rd.py;
          p1[2]  <= a_rd.pz;
          tgi[0] <= b_rd.ix;
          tgi[1] <= b_rd.iy;
          tgi[2] <= b_rd.iz;
          dur_q  <= dur33[VAL_W-1:0];
          rem    <= num33[VAL_W-1:0];
          u      <= '0;
          dc     <= DCW'(F);
          // An empty or reversed segment returns the start position.
          if (dur33[VAL_W] || dur33 == '0)
            state <= S_DONE;
          else if (num33[VAL_W] || num33 == '0)
            state <= S_SQ;
          else if (num33 >= dur33) begin
            u     <= U_MAX;
            state <= S_SQ;
          end else
            state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? VAL_W'(rem2 - {1'b0, dur_q}) : rem2[VAL_W-1:0];
          u   <= {u[F-2:0], ge};
          dc  <= dc - DCW'(1);
          if (dc == DCW'(1))
            state <= S_SQ;
        end
        S_SQ: begin
          u2    <= F'(({{F{1'b0}}, u} * {{F{1'b0}}, u}) >> F);
          state <= S_CU;
        end
        S_CU: begin
          u3    <= F'(({{F{1'b0}}, u2} * {{F{1'b0}}, u}) >> F);
          state <= S_H;
        end
        S_H: begin
          if (lin) begin
            h[0] <= ONE_H - HW'(u);
            h[1] <= '0;
            h[2] <= HW'(u);
            h[3] <= '0;
          end else begin
            h[0] <= (HW'(u3) <<< 1) - HW'(u2) * HW'(3) + ONE_H;
            h[1] <= HW'(u3) - (HW'(u2) <<< 1) + HW'(u);
            h[2] <= HW'(u2) * HW'(3) - (HW'(u3) <<< 1);
            h[3] <= HW'(u3) - HW'(u2);
          end
          mc    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mc != 4'd12) begin
            prod    <= PW'(op) * PW'(wt);
            ax_q    <= ax_sel;
            first_q <= (term == 2'd0);
          end
          if (mc != 4'd0)
            acc[ax_q] <= first_q ? AW'(prod) : acc[ax_q] + AW'(prod);
          mc <= mc + 4'd1;
          if (mc == 4'd12)
            state <= S_FIN;
        end
        S_FIN: begin
          r_x   <= finish(acc[0]);
          r_y   <= finish(acc[1]);
          r_z   <= finish(acc[2]);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_x     <= r_x;
            out_y     <= r_y;
            out_z     <= r_z;
            segment   <= r_seg;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The restoring divider keeps its remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dur_q)
    else $error("divider remainder not below divisor");

  // The search only runs while the bracket still spans more than one key.
  a_srch_span: assert property (@(posedge clk) disable iff (rst)
    state == S_SRCH |-> (hi > lo) && ((hi - lo) > KW'(1)))
    else $error("search bracket collapsed");

  // A taken result leaves the output empty unless a new one is loaded.
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && state != S_DONE |=> !out_valid)
    else $error("result delivered twice");

endmodule

// ===== dv/tb_keyframe_hermite_interpolator.sv =====
// Self-checking testbench for the keyframe Hermite interpolator.
module tb_keyframe_hermite_interpolator;
  import khi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int NKEYS = DEF_MAX_KEYS;
  localparam int FB = DEF_FRAC_BITS;
  localparam longint ONE = longint'(1) << FB;
  localparam int SETTLE = 60;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic signed [VAL_W-1:0] t;
    logic signed [VAL_W-1:0] ax, ay, az;
    logic signed [VAL_W-1:0] bx, by, bz;
    logic lin;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x, y, z;
    logic [IDX_W-1:0] seg;
  } position_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] key_index;
  logic signed [VAL_W-1:0] time_value, vec_a_x, vec_a_y, vec_a_z;
  logic signed [VAL_W-1:0] vec_b_x, vec_b_y, vec_b_z;
  logic linear_flag;
  logic out_valid, out_stall;
  logic signed [VAL_W-1:0] out_x, out_y, out_z;
  logic [IDX_W-1:0] segment;
  logic cfg_valid, cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  keyframe_hermite_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .key_index(key_index), .time_value(time_value),
    .vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
    .vec_b_x(vec_b_x), .vec_b_y(vec_b_y), .vec_b_z(vec_b_z),
    .linear_flag(linear_flag),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .segment(segment),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: the key table as the block should hold it.
  logic [CNT_W-1:0] count_q;
  longint tm_q[NKEYS];
  longint pos_q[NKEYS][3];
  longint otan_q[NKEYS][3];
  longint itan_q[NKEYS][3];
  bit lin_q[NKEYS];

  request_t pending[$];
  position_t expected_pos[$];
  request_t cur;
  bit took;
  int gap_left, burst_left, stall_mode, stall_left;
  int errors;
  int issued;
  // Key times as queued, used to aim queries inside segments.
  int gen_time[NKEYS];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic signed [VAL_W-1:0] round_sat(input longint acc);
    longint r;
    r = (acc + (ONE >>> 1)) >>> FB;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[VAL_W-1:0];
  endfunction

  function automatic position_t key_pos(input int k, input int seg);
    position_t p;
    p.x = pos_q[k][0][VAL_W-1:0];
    p.y = pos_q[k][1][VAL_W-1:0];
    p.z = pos_q[k][2][VAL_W-1:0];
    p.seg = seg[IDX_W-1:0];
    return p;
  endfunction

  function automatic position_t interpolate(input longint t);
    int n, lo, hi, mid, b;
    longint dur, num, u, u2, u3, h1, h2, h3, h4, acc[3];
    position_t p;
    n = (count_q > NKEYS) ? NKEYS : int'(count_q);
    p = '0;
    if (n == 0) return p;
    if (n == 1 || t <= tm_q[0]) return key_pos(0, 0);
    if (t >= tm_q[n-1]) return key_pos(n - 1, n - 1);
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (tm_q[mid] <= t) lo = mid;
      else hi = mid;
    end
    b = lo + 1;
    dur = tm_q[b] - tm_q[lo];
    num = t - tm_q[lo];
    if (dur <= 0) return key_pos(lo, lo);
    if (num <= 0) u = 0;
    else begin
      u = (num <<< FB) / dur;
      if (u > ONE - 1) u = ONE - 1;
    end
    u2 = (u * u) >>> FB;
    u3 = (u2 * u) >>> FB;
    h1 = 2 * u3 - 3 * u2 + ONE;
    h2 = u3 - 2 * u2 + u;
    h3 = -2 * u3 + 3 * u2;
    h4 = u3 - u2;
    for (int c = 0; c < 3; c++) begin
      if (lin_q[lo])
        acc[c] = pos_q[lo][c] * (ONE - u) + pos_q[b][c] * u;
      else
        acc[c] = pos_q[lo][c] * h1 + otan_q[lo][c] * h2
               + pos_q[b][c] * h3 + itan_q[b][c] * h4;
    end
    p.x = round_sat(acc[0]);
    p.y = round_sat(acc[1]);
    p.z = round_sat(acc[2]);
    p.seg = lo[IDX_W-1:0];
    return p;
  endfunction

  // Applies one accepted request to the predicted table and queues the expected result of an evaluate.
  task automatic apply_request(input request_t r);
    case (r.cmd)
      CMD_KEY: begin
        tm_q[r.idx] = r.t;
        pos_q[r.idx][0] = r.ax;
        pos_q[r.idx][1] = r.ay;
        pos_q[r.idx][2] = r.az;
        lin_q[r.idx] = r.lin;
      end
      CMD_TAN: begin
        otan_q[r.idx][0] = r.ax;
        otan_q[r.idx][1] = r.ay;
        otan_q[r.idx][2] = r.az;
        itan_q[r.idx][0] = r.bx;
        itan_q[r.idx][1] = r.by;
        itan_q[r.idx][2] = r.bz;
      end
      CMD_EVAL: expected_pos.insert(expected_pos.size(), interpolate(r.t));
      default: ;
    endcase
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      apply_request(cur);
      took = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && !took)) begin
      took = 0;
      if (gap_left == 0 && burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        cur = pending.pop_front();
        burst_left--;
        in_valid <= 1;
        cmd <= cur.cmd;
        key_index <= cur.idx;
        time_value <= cur.t;
        vec_a_x <= cur.ax;
        vec_a_y <= cur.ay;
        vec_a_z <= cur.az;
        vec_b_x <= cur.bx;
        vec_b_y <= cur.by;
        vec_b_z <= cur.bz;
        linear_flag <= cur.lin;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Receiver: stall pattern that changes mode at random intervals.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    position_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pos.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_pos.pop_front();
        if (out_x !== w.x) report_mismatch("out_x", out_x, w.x);
        if (out_y !== w.y) report_mismatch("out_y", out_y, w.y);
        if (out_z !== w.z) report_mismatch("out_z", out_z, w.z);
        if (segment !== w.seg) report_mismatch("segment", segment, w.seg);
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) == 0) ? 32'sh80000000 : 32'sh7fffffff;
      2: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  task automatic queue_req(input logic [CMD_W-1:0] c, input int k, input int t, input bit lin);
    request_t r;
    r.cmd = c;
    r.idx = k[IDX_W-1:0];
    r.t = t;
    r.ax = rand_val();
    r.ay = rand_val();
    r.az = rand_val();
    r.bx = rand_val();
    r.by = rand_val();
    r.bz = rand_val();
    r.lin = lin;
    if (c == CMD_KEY) gen_time[k] = t;
    pending.insert(pending.size(), r);
    issued++;
  endtask

  // Loads keys 0..n-1 with non-decreasing times (repeated times allowed), or shuffled.
  task automatic load_keys(input int n, input bit shuffled);
    int t;
    t = $signed($urandom_range(0, 1 << 30)) - (1 << 30);
    for (int k = 0; k < n; k++) begin
      queue_req(CMD_KEY, k, shuffled ? int'($urandom) : t, $urandom_range(0, 2) == 0);
      queue_req(CMD_TAN, k, $urandom, $urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0)
        t += $urandom_range(1, 1 << $urandom_range(4, 26));
    end
  endtask

  task automatic queue_eval(input int n);
    int i;
    longint t;
    case ($urandom_range(0, 19))
      0: t = 32'sh80000000;
      1: t = 32'sh7fffffff;
      2, 3: t = $signed($urandom);
      4: t = gen_time[$urandom_range(0, NKEYS - 1)];
      default: begin
        i = (n > 1) ? $urandom_range(0, n - 2) : 0;
        t = gen_time[i];
        if (n > 1 && gen_time[i+1] > gen_time[i])
          t += $urandom_range(0, gen_time[i+1] - gen_time[i]);
      end
    endcase
    queue_req(CMD_EVAL, $urandom, int'(t), $urandom_range(0, 1));
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_valid || expected_pos.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    count_q = v[CNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    int n;
    rst = 1;
    in_valid = 0;
    cmd = CMD_NONE;
    key_index = 0;
    time_value = 0;
    vec_a_x = 0; vec_a_y = 0; vec_a_z = 0;
    vec_b_x = 0; vec_b_y = 0; vec_b_z = 0;
    linear_flag = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = 0;
    count_q = 0;
    took = 0;
    gap_left = 0; burst_left = 0; stall_left = 0;
    errors = 0; issued = 0;
    for (int k = 0; k < NKEYS; k++) begin
      tm_q[k] = 0;
      lin_q[k] = 0;
      for (int c = 0; c < 3; c++) begin
        pos_q[k][c] = 0; otan_q[k][c] = 0; itan_q[k][c] = 0;
      end
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Empty table returns zero; then a full load and the single-key case.
    write_count(0);
    queue_req(CMD_EVAL, 0, 0, 0);
    queue_req(CMD_EVAL, 15, 32'sh7fffffff, 1);
    queue_req(CMD_NONE, 7, 0, 0);
    load_keys(NKEYS, 0);
    write_count(1);
    queue_req(CMD_EVAL, 0, 32'sh80000000, 0);
    queue_req(CMD_EVAL, 0, 32'sh7fffffff, 0);
    // A count above the table size is treated as the full table.
    write_count(31);
    queue_req(CMD_EVAL, 0, 32'sh80000000, 0);
    queue_req(CMD_EVAL, 0, 32'sh7fffffff, 0);
    queue_req(CMD_EVAL, 0, gen_time[0], 0);
    queue_req(CMD_EVAL, 0, gen_time[NKEYS-1], 0);
    for (int i = 0; i < 8; i++) queue_eval(NKEYS);

    while (issued < 400) begin
      case ($urandom_range(0, 7))
        0: n = $urandom_range(17, 31);
        1: n = $urandom_range(0, 2);
        2: n = 16;
        default: n = $urandom_range(2, 16);
      endcase
      write_count(n);
      if (n > NKEYS) n = NKEYS;
      load_keys(n, $urandom_range(0, 4) == 0);
      repeat ($urandom_range(20, 40)) begin
        case ($urandom_range(0, 19))
          0: queue_req(CMD_NONE, $urandom, $urandom, $urandom_range(0, 1));
          1: queue_req(CMD_TAN, $urandom_range(0, NKEYS - 1), $urandom, 0);
          2: queue_req(CMD_KEY, $urandom_range(0, NKEYS - 1), $urandom, $urandom_range(0, 1));
          default: queue_eval(n);
        endcase
      end
    end

    wait_idle();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
